// File: rtl/itp_pkg.sv
// Shared types, constants and character helpers of the infix to postfix converter.
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = $clog2(STACK_DEPTH);

    localparam logic [7:0] LPAREN_CHAR = 8'h28;
    localparam logic [7:0] RPAREN_CHAR = 8'h29;
    localparam logic [7:0] PLUS_CHAR   = 8'h2B;
    localparam logic [7:0] MINUS_CHAR  = 8'h2D;
    localparam logic [7:0] MUL_CHAR    = 8'h2A;
    localparam logic [7:0] DIV_CHAR    = 8'h2F;

    typedef enum logic [2:0] {
        CODE_NONE   = 3'd0,
        CODE_LPAREN = 3'd1,
        CODE_PLUS   = 3'd2,
        CODE_MINUS  = 3'd3,
        CODE_MUL    = 3'd4,
        CODE_DIV    = 3'd5
    } op_code_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNMATCHED = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    typedef struct packed {
        logic     push;
        logic     pop;
        op_code_t code;
    } stk_ctrl_t;

    function automatic op_code_t classify(logic [7:0] c);
        op_code_t r;
        case (c)
            LPAREN_CHAR: r = CODE_LPAREN;
            PLUS_CHAR:   r = CODE_PLUS;
            MINUS_CHAR:  r = CODE_MINUS;
            MUL_CHAR:    r = CODE_MUL;
            DIV_CHAR:    r = CODE_DIV;
            default:     r = CODE_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] priority_of(op_code_t code);
        logic [1:0] r;
        case (code)
            CODE_PLUS, CODE_MINUS: r = 2'd1;
            CODE_MUL, CODE_DIV:    r = 2'd2;
            default:               r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_char(op_code_t code);
        logic [7:0] r;
        case (code)
            CODE_LPAREN: r = LPAREN_CHAR;
            CODE_PLUS:   r = PLUS_CHAR;
            CODE_MINUS:  r = MINUS_CHAR;
            CODE_MUL:    r = MUL_CHAR;
            CODE_DIV:    r = DIV_CHAR;
            default:     r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/itp_stack.sv
// Operator stack: register array with an occupancy count and a top-of-stack read.
module itp_stack (
    input  logic                      clk,
    input  logic                      rst_n,
    input  itp_pkg::stk_ctrl_t        ctrl,
    output logic [itp_pkg::CNT_W-1:0] count,
    output itp_pkg::op_code_t         top
);

    itp_pkg::op_code_t          entry_mem [itp_pkg::STACK_DEPTH];
    logic [itp_pkg::CNT_W-1:0]  count_reg;
    logic [itp_pkg::CNT_W-1:0]  count_next;
    logic [itp_pkg::CNT_W-1:0]  top_addr;

    // Entries are written only at the free slot; the sequencer never pushes on a full stack.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            entry_mem[count_reg[itp_pkg::IDX_W-1:0]] <= ctrl.code;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + {{(itp_pkg::CNT_W-1){1'b0}}, 1'b1};
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - {{(itp_pkg::CNT_W-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // The top is only meaningful while the count is nonzero.
    assign top_addr = count_reg - {{(itp_pkg::CNT_W-1){1'b0}}, 1'b1};
    assign top      = entry_mem[top_addr[itp_pkg::IDX_W-1:0]];
    assign count    = count_reg;

endmodule

// File: rtl/infix_to_postfix_converter_top.sv
// Top level of the infix to postfix converter: step sequencer, result buffering and ports.
//
// This block turns a stream of infix ASCII characters into the postfix character stream
// with a shunting-yard operator stack of 32 entries. One character is taken per input
// transfer and the block stalls its input until that character is fully handled. An operand
// or a '(' passes through accept, one stack step and close, and every operator popped to
// the output adds a step, because the sequencer performs at most one stack push or pop per
// cycle. On the end-of-expression character the flush pops every entry from the stack and
// then checks that it is empty. Output stall holds back any step that would give a result.
// A character may give no result at all (a pushed '(' or operator), and the final result
// caused by a character carries last_of_run. An unmatched ')' and a push onto a full stack
// each give one result with out_char 0 and a nonzero status, and the offending character is
// dropped. After the end-of-expression character the stack is empty and the next character
// starts a new expression. There is no clearing pass after reset.
module infix_to_postfix_converter_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       end_of_expr,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       last_of_run,
    output logic [1:0] status
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROC  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    state_t                    after_item;

    // The character under work.
    logic [7:0]                ch_reg;
    logic                      eoe_reg;
    itp_pkg::op_code_t         code_reg;

    // One result is held back until it is known whether another one follows it.
    logic                      hold_valid_reg;
    logic [7:0]                hold_char_reg;
    itp_pkg::status_t          hold_status_reg;

    // Output register, parting the sequencer from the downstream stall.
    logic                      out_valid_reg;
    logic [7:0]                out_char_reg;
    logic                      out_last_reg;
    itp_pkg::status_t          out_status_reg;

    itp_pkg::stk_ctrl_t        stk_ctrl;
    logic [itp_pkg::CNT_W-1:0] stk_count;
    itp_pkg::op_code_t         stk_top;

    logic                      stack_empty;
    logic                      stack_full;
    logic                      top_is_lparen;
    logic                      top_binds;
    logic                      out_free;
    logic                      slot_ok;
    logic                      emit;
    logic [7:0]                emit_char;
    itp_pkg::status_t          emit_status;
    logic                      finish;
    logic                      load_out;

    itp_stack u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (stk_ctrl),
        .count (stk_count),
        .top   (stk_top)
    );

    assign stack_empty   = (stk_count == '0);
    assign stack_full    = (stk_count >= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
    assign top_is_lparen = (stk_top == itp_pkg::CODE_LPAREN);

    // The single priority compare, reused on every pop decision of an operator.
    assign top_binds = (itp_pkg::priority_of(stk_top) >= itp_pkg::priority_of(code_reg));

    // A new result may be produced when no result is held or the held one can move on to the output register.
    assign out_free = !out_valid_reg || !out_stall;
    assign slot_ok  = !hold_valid_reg || out_free;

    assign after_item = eoe_reg ? S_FLUSH : S_DONE;

    always_comb
    begin
        state_next    = state_reg;
        stk_ctrl.push = 1'b0;
        stk_ctrl.pop  = 1'b0;
        stk_ctrl.code = code_reg;
        emit          = 1'b0;
        emit_char     = 8'h00;
        emit_status   = itp_pkg::ST_OK;
        finish        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PROC;
                end
            end

            S_PROC:
            begin
                if (ch_reg == itp_pkg::RPAREN_CHAR)
                begin
                    if (!stack_empty && !top_is_lparen)
                    begin
                        if (slot_ok)
                        begin
                            stk_ctrl.pop = 1'b1;
                            emit         = 1'b1;
                            emit_char    = itp_pkg::code_char(stk_top);
                        end
                    end
                    else if (stack_empty)
                    begin
                        if (slot_ok)
                        begin
                            emit        = 1'b1;
                            emit_status = itp_pkg::ST_UNMATCHED;
                            state_next  = after_item;
                        end
                    end
                    else
                    begin
                        // The matching '(' is discarded.
                        stk_ctrl.pop = 1'b1;
                        state_next   = after_item;
                    end
                end
                else if (code_reg == itp_pkg::CODE_NONE)
                begin
                    if (slot_ok)
                    begin
                        emit       = 1'b1;
                        emit_char  = ch_reg;
                        state_next = after_item;
                    end
                end
                else if (code_reg != itp_pkg::CODE_LPAREN && !stack_empty &&
                         !top_is_lparen && top_binds)
                begin
                    if (slot_ok)
                    begin
                        stk_ctrl.pop = 1'b1;
                        emit         = 1'b1;
                        emit_char    = itp_pkg::code_char(stk_top);
                    end
                end
                else if (stack_full)
                begin
                    if (slot_ok)
                    begin
                        emit        = 1'b1;
                        emit_status = itp_pkg::ST_OVERFLOW;
                        state_next  = after_item;
                    end
                end
                else
                begin
                    stk_ctrl.push = 1'b1;
                    state_next    = after_item;
                end
            end

            S_FLUSH:
            begin
                if (stack_empty)
                begin
                    state_next = S_DONE;
                end
                else if (top_is_lparen)
                begin
                    stk_ctrl.pop = 1'b1;
                end
                else if (slot_ok)
                begin
                    stk_ctrl.pop = 1'b1;
                    emit         = 1'b1;
                    emit_char    = itp_pkg::code_char(stk_top);
                end
            end

            S_DONE:
            begin
                // The held result, if any, is the last one of this character.
                if (!hold_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign load_out = (emit && hold_valid_reg) || finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (emit)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (finish)
            begin
                hold_valid_reg <= 1'b0;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            ch_reg   <= in_char;
            eoe_reg  <= end_of_expr;
            code_reg <= itp_pkg::classify(in_char);
        end

        if (emit)
        begin
            hold_char_reg   <= emit_char;
            hold_status_reg <= emit_status;
        end

        if (load_out)
        begin
            out_char_reg   <= hold_char_reg;
            out_status_reg <= hold_status_reg;
            out_last_reg   <= finish;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign last_of_run = out_last_reg;
    assign status      = out_status_reg;

endmodule

// File: rtl/itp_checker.sv
// Port-level assertions for the infix to postfix converter, bound to its top level.
module itp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_char,
    input logic       end_of_expr,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       last_of_run,
    input logic [1:0] status
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(status) &&
        $stable(last_of_run))
        else $error("stalled result changed");

    // Error results carry a zero character.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != itp_pkg::ST_OK |-> out_char == 8'h00)
        else $error("error result with nonzero character");

    // A character is still worked on in the cycle after its transfer, so the input is stalled then.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after a transfer");

    // Only defined status codes appear.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == itp_pkg::ST_OK || status == itp_pkg::ST_UNMATCHED ||
        status == itp_pkg::ST_OVERFLOW)
        else $error("undefined status code");

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (.*);
